/* rtl/uer_pkg.sv */
// Shared types and constants for the ultrasonic echo ranging block.
// Used by uer_cfg, uer_step and ultrasonic_echo_ranging; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package uer_pkg;

  localparam int unsigned CfgIdxBits = 2;
  localparam int unsigned CfgDataBits = 16;
  localparam int unsigned WinBits = 18;

  localparam logic [CfgIdxBits-1:0] CFG_MAX_DISTANCE = 2'd0;
  localparam logic [CfgIdxBits-1:0] CFG_ROUNDTRIP = 2'd1;
  localparam logic [CfgIdxBits-1:0] CFG_WARMUP = 2'd2;
  localparam logic [CfgIdxBits-1:0] CFG_OVERHEAD = 2'd3;

  localparam logic [9:0] MaxDistanceReset = 10'd500;
  localparam logic [7:0] RoundtripReset = 8'd57;
  localparam logic [15:0] WarmupReset = 16'd5800;
  localparam logic [7:0] OverheadReset = 8'd5;
  localparam logic [WinBits-1:0] WindowReset = WinBits'(500 * 57 + 57 / 2);

  localparam int unsigned LowTicks = 4;
  localparam int unsigned HighTicks = 10;

  typedef enum logic [2:0] {
    PH_IDLE      = 3'd0,
    PH_TRIG_LOW  = 3'd1,
    PH_TRIG_HIGH = 3'd2,
    PH_WAIT_RISE = 3'd3,
    PH_WAIT_FALL = 3'd4
  } uer_phase_t;

  typedef struct packed {
    logic        trigger_level;
    logic        busy_res;
    logic        done_res;
    logic        timed_out;
    logic [15:0] echo_us;
  } uer_result_t;

endpackage

`default_nettype wire

/* rtl/uer_cfg.sv */
// Configuration registers and the registered echo deadline window.
// Depends on uer_pkg.
`timescale 1ns / 1ps
`default_nettype none

module uer_cfg
  import uer_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_we,
  input  wire logic [CfgIdxBits-1:0]  cfg_index,
  input  wire logic [CfgDataBits-1:0] cfg_data,
  output logic [15:0]                 warmup_timeout_us,
  output logic [7:0]                  ping_overhead_us,
  output logic [WinBits-1:0]          echo_window
);

  logic [9:0] dist_limit_cm;
  logic [7:0] roundtrip_us_per_cm;

  always_ff @(posedge clk) begin
    if (rst) begin
      dist_limit_cm <= MaxDistanceReset;
      roundtrip_us_per_cm <= RoundtripReset;
      warmup_timeout_us <= WarmupReset;
      ping_overhead_us <= OverheadReset;
      echo_window <= WindowReset;
    end else begin
      echo_window <= WinBits'(dist_limit_cm) * WinBits'(roundtrip_us_per_cm)
                     + WinBits'(roundtrip_us_per_cm >> 1);
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_MAX_DISTANCE: dist_limit_cm <= cfg_data[9:0];
          CFG_ROUNDTRIP:    roundtrip_us_per_cm <= cfg_data[7:0];
          CFG_WARMUP:       warmup_timeout_us <= cfg_data;
          CFG_OVERHEAD:     ping_overhead_us <= cfg_data[7:0];
        endcase
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/uer_step.sv */
// Next-state and result logic for one beat of the ranging sequencer.
// Depends on uer_pkg.
`timescale 1ns / 1ps
`default_nettype none

module uer_step
  import uer_pkg::*;
#(
  parameter int unsigned TIME_BITS = 16
) (
  input  wire uer_phase_t             phase,
  input  wire logic [TIME_BITS-1:0]   elapsed_us,
  input  wire logic [TIME_BITS-1:0]   echo_start_us,
  input  wire logic [TIME_BITS-1:0]   deadline_us,
  input  wire logic                   kind,
  input  wire logic                   echo_level,
  input  wire logic [15:0]            warmup_timeout_us,
  input  wire logic [7:0]             ping_overhead_us,
  input  wire logic [WinBits-1:0]     echo_window,
  output uer_phase_t                  phase_next,
  output logic [TIME_BITS-1:0]        elapsed_us_next,
  output logic [TIME_BITS-1:0]        echo_start_us_next,
  output logic [TIME_BITS-1:0]        deadline_us_next,
  output uer_result_t                 result
);

  localparam int unsigned SumBits = ((TIME_BITS > WinBits) ? TIME_BITS : WinBits) + 1;
  localparam int unsigned WidBits = (TIME_BITS > 16) ? TIME_BITS : 16;
  localparam logic [TIME_BITS-1:0] TimeMax = '1;

  uer_phase_t             ph;
  logic [TIME_BITS-1:0]   el_inc;
  logic [SumBits-1:0]     rise_sum;
  logic [SumBits-1:0]     fall_sum;
  logic [TIME_BITS-1:0]   rise_deadline;
  logic [TIME_BITS-1:0]   fall_deadline;
  logic                   passed;
  logic [TIME_BITS-1:0]   width;
  logic [WidBits-1:0]     width_x;
  logic [WidBits-1:0]     ovh_x;
  logic [WidBits-1:0]     width_net;
  logic [15:0]            width_out;
  logic                   done;
  logic                   tmo;
  logic [15:0]            echo_val;

  always_comb begin
    ph = (phase > PH_WAIT_FALL) ? PH_IDLE : phase;
    el_inc = (elapsed_us != TimeMax) ? elapsed_us + TIME_BITS'(1) : elapsed_us;

    rise_sum = SumBits'(el_inc) + SumBits'(warmup_timeout_us);
    rise_deadline = (rise_sum > SumBits'(TimeMax)) ? TimeMax : rise_sum[TIME_BITS-1:0];
    fall_sum = SumBits'(el_inc) + SumBits'(echo_window);
    fall_deadline = (fall_sum > SumBits'(TimeMax)) ? TimeMax : fall_sum[TIME_BITS-1:0];

    passed = (el_inc > deadline_us) || (el_inc == TimeMax);

    width = el_inc - echo_start_us;
    width_x = WidBits'(width);
    ovh_x = WidBits'(ping_overhead_us);
    width_net = (width_x > ovh_x) ? width_x - ovh_x : '0;
    width_out = (width_net > WidBits'(16'hFFFF)) ? 16'hFFFF : width_net[15:0];
  end

  always_comb begin
    phase_next = ph;
    elapsed_us_next = elapsed_us;
    echo_start_us_next = echo_start_us;
    deadline_us_next = deadline_us;
    done = 1'b0;
    tmo = 1'b0;
    echo_val = '0;
    if (kind) begin
      if (ph == PH_IDLE) begin
        elapsed_us_next = '0;
        phase_next = PH_TRIG_LOW;
      end
    end else if (ph != PH_IDLE) begin
      elapsed_us_next = el_inc;
      unique case (ph)
        PH_TRIG_LOW: begin
          if (el_inc >= TIME_BITS'(LowTicks)) begin
            phase_next = PH_TRIG_HIGH;
          end
        end
        PH_TRIG_HIGH: begin
          if (el_inc >= TIME_BITS'(LowTicks + HighTicks)) begin
            phase_next = PH_WAIT_RISE;
            deadline_us_next = rise_deadline;
          end
        end
        PH_WAIT_RISE: begin
          if (echo_level) begin
            echo_start_us_next = el_inc;
            deadline_us_next = fall_deadline;
            phase_next = PH_WAIT_FALL;
          end else if (passed) begin
            done = 1'b1;
            tmo = 1'b1;
            phase_next = PH_IDLE;
          end
        end
        PH_WAIT_FALL: begin
          if (!echo_level) begin
            echo_val = width_out;
            done = 1'b1;
            phase_next = PH_IDLE;
          end else if (passed) begin
            done = 1'b1;
            tmo = 1'b1;
            phase_next = PH_IDLE;
          end
        end
        default: phase_next = PH_IDLE;
      endcase
    end

    result.trigger_level = (phase_next == PH_TRIG_HIGH);
    result.busy_res = (phase_next != PH_IDLE);
    result.done_res = done;
    result.timed_out = tmo;
    result.echo_us = echo_val;
  end

endmodule

`default_nettype wire

/* rtl/ultrasonic_echo_ranging.sv */
// Top level of the ultrasonic echo ranging controller.
// Depends on uer_pkg, uer_cfg and uer_step.
//
// Each input beat is either a one-microsecond tick carrying the sampled echo
// pin level (kind 0) or a request to start a ping (kind 1). Every input beat
// produces exactly one output beat with the trigger level to drive, the busy
// flag, and on the finishing beat the done flag, the timeout flag and the echo
// width in microseconds minus the configured overhead.
// An input beat is taken on the cycle it is offered if the output register is
// empty or being drained, so one beat per cycle is sustained; the result
// appears in the cycle after acceptance. The state update and the result are
// computed in a single pass between the state registers and the output
// register. When the receiver stalls, the held result blocks further input
// until it is taken. Configuration writes are registered, and the echo deadline
// window derived from them is registered from those registers in turn. The user
// must make writes only while no ping is running; the block does not enforce it.
// Reset clears the sequencer to idle, empties the output register and loads
// the default configuration.
`timescale 1ns / 1ps
`default_nettype none

module ultrasonic_echo_ranging
  import uer_pkg::*;
#(
  parameter int unsigned TIME_BITS = 16
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic                   kind,
  input  wire logic                   echo_level,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic                        trigger_level,
  output logic                        busy_res,
  output logic                        done_res,
  output logic                        timed_out,
  output logic [15:0]                 echo_us,
  input  wire logic                   cfg_we,
  input  wire logic [CfgIdxBits-1:0]  cfg_index,
  input  wire logic [CfgDataBits-1:0] cfg_data
);

  logic [15:0]          warmup_timeout_us;
  logic [7:0]           ping_overhead_us;
  logic [WinBits-1:0]   echo_window;

  uer_phase_t           phase;
  uer_phase_t           phase_next;
  logic [TIME_BITS-1:0] elapsed_us;
  logic [TIME_BITS-1:0] elapsed_us_next;
  logic [TIME_BITS-1:0] echo_start_us;
  logic [TIME_BITS-1:0] echo_start_us_next;
  logic [TIME_BITS-1:0] deadline_us;
  logic [TIME_BITS-1:0] deadline_us_next;
  uer_result_t          result_next;
  uer_result_t          result;
  logic                 accept;

  uer_cfg u_cfg (
    .clk               (clk),
    .rst               (rst),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .warmup_timeout_us (warmup_timeout_us),
    .ping_overhead_us  (ping_overhead_us),
    .echo_window       (echo_window)
  );

  uer_step #(
    .TIME_BITS (TIME_BITS)
  ) u_step (
    .phase              (phase),
    .elapsed_us         (elapsed_us),
    .echo_start_us      (echo_start_us),
    .deadline_us        (deadline_us),
    .kind               (kind),
    .echo_level         (echo_level),
    .warmup_timeout_us  (warmup_timeout_us),
    .ping_overhead_us   (ping_overhead_us),
    .echo_window        (echo_window),
    .phase_next         (phase_next),
    .elapsed_us_next    (elapsed_us_next),
    .echo_start_us_next (echo_start_us_next),
    .deadline_us_next   (deadline_us_next),
    .result             (result_next)
  );

  assign in_ready = !out_valid || out_ready;
  assign accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      elapsed_us <= '0;
      echo_start_us <= '0;
      deadline_us <= '0;
      out_valid <= 1'b0;
    end else if (accept) begin
      phase <= phase_next;
      elapsed_us <= elapsed_us_next;
      echo_start_us <= echo_start_us_next;
      deadline_us <= deadline_us_next;
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result <= result_next;
    end
  end

  assign trigger_level = result.trigger_level;
  assign busy_res = result.busy_res;
  assign done_res = result.done_res;
  assign timed_out = result.timed_out;
  assign echo_us = result.echo_us;

  a_done_ends_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && done_res |-> !busy_res)
    else $error("done beat still reports busy");

  a_timeout_zero_width: assert property (@(posedge clk) disable iff (rst)
    out_valid && timed_out |-> done_res && (echo_us == 16'd0))
    else $error("timeout beat without done or with nonzero width");

  a_trigger_in_ping: assert property (@(posedge clk) disable iff (rst)
    out_valid && trigger_level |-> busy_res && (phase == PH_TRIG_HIGH))
    else $error("trigger high outside the trigger phase");

  a_accept_fills_output: assert property (@(posedge clk) disable iff (rst)
    accept |=> out_valid)
    else $error("accepted beat produced no result");

endmodule

`default_nettype wire

/* tb/tb_top.sv */
// Self-checking testbench for the ultrasonic echo ranging controller.
// Drives tick and start beats, predicts each status beat or uses a fixed one, and compares it.
// Depends on uer_pkg and ultrasonic_echo_ranging.
`timescale 1ns / 1ps

module tb_top;
  import uer_pkg::*;

  localparam logic [15:0] TimeMax = 16'hFFFF;
  localparam int NumPhases = 7;

  localparam uer_result_t ResIdle = '0;
  localparam uer_result_t ResBusy = '{trigger_level: 1'b0, busy_res: 1'b1, done_res: 1'b0,
                                      timed_out: 1'b0, echo_us: 16'd0};
  localparam uer_result_t ResShortEcho = '{trigger_level: 1'b0, busy_res: 1'b0,
                                           done_res: 1'b1, timed_out: 1'b0, echo_us: 16'd0};

  typedef struct packed {
    logic        start;
    logic        echo;
    logic [7:0]  reps;
    logic        typed;
    uer_result_t res;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic kind = 1'b0;
  logic echo_level = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic trigger_level;
  logic busy_res;
  logic done_res;
  logic timed_out;
  logic [15:0] echo_us;
  logic cfg_we = 1'b0;
  logic [CfgIdxBits-1:0] cfg_index = '0;
  logic [CfgDataBits-1:0] cfg_data = '0;

  // Predicted controller state and its register copies.
  uer_phase_t p_phase = PH_IDLE;
  logic [15:0] p_elapsed = '0;
  logic [15:0] p_echo_start = '0;
  logic [15:0] p_deadline = '0;
  logic [9:0] c_max_dist = MaxDistanceReset;
  logic [7:0] c_rt = RoundtripReset;
  logic [15:0] c_warmup = WarmupReset;
  logic [7:0] c_overhead = OverheadReset;

  uer_result_t pending_status[$];
  int errors = 0;
  int n_beats = 0;
  int n_done = 0;
  int n_timeouts = 0;
  int burst_left = 0;

  int unsigned ph_dist[NumPhases] = '{3, 0, 1000, 7, 2, 1000, 500};
  int unsigned ph_rt[NumPhases] = '{4, 0, 1, 255, 3, 255, 57};
  int unsigned ph_warmup[NumPhases] = '{10, 0, 20, 65535, 5, 65535, 5800};
  int unsigned ph_overhead[NumPhases] = '{2, 0, 255, 100, 1, 0, 5};

  dir_row_t dir_rows[8];

  ultrasonic_echo_ranging dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .kind(kind),
    .echo_level(echo_level),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .trigger_level(trigger_level),
    .busy_res(busy_res),
    .done_res(done_res),
    .timed_out(timed_out),
    .echo_us(echo_us),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #15_000_000;
    $display("[ultrasonic_echo_ranging] ERROR");
    $finish;
  end

  function automatic logic [15:0] sat_time(input int unsigned v);
    return (v > 32'hFFFF) ? TimeMax : 16'(v);
  endfunction

  function automatic int unsigned echo_window();
    return int'(c_max_dist) * int'(c_rt) + int'(c_rt) / 2;
  endfunction

  function automatic bit deadline_passed();
    return p_elapsed > p_deadline || p_elapsed == TimeMax;
  endfunction

  task automatic advance_ranger(input logic start, input logic echo, output uer_result_t r);
    logic [15:0] width;
    r = '0;
    if (start) begin
      if (p_phase == PH_IDLE) begin
        p_elapsed = '0;
        p_phase = PH_TRIG_LOW;
      end
    end else if (p_phase != PH_IDLE) begin
      if (p_elapsed != TimeMax) p_elapsed = p_elapsed + 16'd1;
      case (p_phase)
        PH_TRIG_LOW: begin
          if (p_elapsed >= 16'(LowTicks)) p_phase = PH_TRIG_HIGH;
        end
        PH_TRIG_HIGH: begin
          if (p_elapsed >= 16'(LowTicks + HighTicks)) begin
            p_phase = PH_WAIT_RISE;
            p_deadline = sat_time(int'(p_elapsed) + int'(c_warmup));
          end
        end
        PH_WAIT_RISE: begin
          if (echo) begin
            p_echo_start = p_elapsed;
            p_deadline = sat_time(int'(p_elapsed) + echo_window());
            p_phase = PH_WAIT_FALL;
          end else if (deadline_passed()) begin
            r.done_res = 1'b1;
            r.timed_out = 1'b1;
            p_phase = PH_IDLE;
          end
        end
        default: begin
          if (!echo) begin
            width = p_elapsed - p_echo_start;
            r.echo_us = (width > 16'(c_overhead)) ? width - 16'(c_overhead) : 16'd0;
            r.done_res = 1'b1;
            p_phase = PH_IDLE;
          end else if (deadline_passed()) begin
            r.done_res = 1'b1;
            r.timed_out = 1'b1;
            p_phase = PH_IDLE;
          end
        end
      endcase
    end
    r.trigger_level = (p_phase == PH_TRIG_HIGH);
    r.busy_res = (p_phase != PH_IDLE);
  endtask

  task automatic send_beat(input logic start, input logic echo, input logic typed,
                           input uer_result_t typed_res);
    uer_result_t r;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 20);
    end
    in_valid <= 1'b1;
    kind <= start;
    echo_level <= echo;
    do @(posedge clk); while (!in_ready);
    if (burst_left > 0) burst_left--;
    advance_ranger(start, echo, r);
    pending_status.push_back(typed ? typed_res : r);
    n_beats++;
  endtask

  task automatic run_ping(input int unsigned rise_wait, input int unsigned width);
    int unsigned n;
    send_beat(1'b1, 1'($urandom), 1'b0, '0);
    while (p_phase == PH_TRIG_LOW || p_phase == PH_TRIG_HIGH)
      send_beat($urandom_range(0, 15) == 0, 1'($urandom), 1'b0, '0);
    n = 0;
    while (p_phase == PH_WAIT_RISE && n < rise_wait) begin
      send_beat($urandom_range(0, 15) == 0, 1'b0, 1'b0, '0);
      n++;
    end
    n = 0;
    while (p_phase != PH_IDLE && n < width) begin
      send_beat($urandom_range(0, 15) == 0, 1'b1, 1'b0, '0);
      n++;
    end
    while (p_phase != PH_IDLE) send_beat(1'b0, 1'b0, 1'b0, '0);
  endtask

  task automatic write_reg(input logic [CfgIdxBits-1:0] idx, input int unsigned value);
    logic [CfgDataBits-1:0] data;
    data = 16'($urandom);
    case (idx)
      CFG_MAX_DISTANCE: data[9:0] = value[9:0];
      CFG_WARMUP: data = value[15:0];
      default: data[7:0] = value[7:0];
    endcase
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    case (idx)
      CFG_MAX_DISTANCE: c_max_dist = data[9:0];
      CFG_ROUNDTRIP: c_rt = data[7:0];
      CFG_WARMUP: c_warmup = data;
      default: c_overhead = data[7:0];
    endcase
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    burst_left = 0;
    while (pending_status.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic report_field(input string field, input int unsigned want,
                              input int unsigned got);
    errors++;
    $display("%t mismatch on %s: expected %0d, got %0d", $time, field, want, got);
  endtask

  always @(posedge clk) begin : status_check
    uer_result_t got;
    uer_result_t want;
    if (!rst && out_valid && out_ready) begin
      got = '{trigger_level, busy_res, done_res, timed_out, echo_us};
      if (pending_status.size() == 0) begin
        errors++;
        $display("%t unexpected status beat: expected none, got %h", $time, got);
      end else begin
        want = pending_status.pop_front();
        if (want.done_res) n_done++;
        if (want.timed_out) n_timeouts++;
        if (got.trigger_level !== want.trigger_level)
          report_field("trigger_level", want.trigger_level, got.trigger_level);
        if (got.busy_res !== want.busy_res)
          report_field("busy_res", want.busy_res, got.busy_res);
        if (got.done_res !== want.done_res)
          report_field("done_res", want.done_res, got.done_res);
        if (got.timed_out !== want.timed_out)
          report_field("timed_out", want.timed_out, got.timed_out);
        if (got.echo_us !== want.echo_us)
          report_field("echo_us", want.echo_us, got.echo_us);
      end
    end
  end

  // The receiver starts with a long hold-off so that the directed beats back up.
  initial begin : receiver
    int unsigned n;
    int unsigned pct;
    @(posedge clk);
    while (rst) @(posedge clk);
    repeat (80) @(posedge clk);
    forever begin
      n = $urandom_range(5, 60);
      case ($urandom_range(0, 9))
        0: begin
          pct = 0;
          n = $urandom_range(30, 150);
        end
        1, 2, 3: pct = 100;
        default: pct = $urandom_range(20, 90);
      endcase
      repeat (n) begin
        out_ready <= ($urandom_range(1, 100) <= pct);
        @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    int unsigned rise;
    int unsigned wmax;
    int unsigned win;
    dir_rows = '{
      '{1'b0, 1'b1, 8'd1, 1'b1, ResIdle},
      '{1'b1, 1'b1, 8'd1, 1'b1, ResBusy},
      '{1'b1, 1'b0, 8'd1, 1'b1, ResBusy},
      '{1'b0, 1'b1, 8'd3, 1'b0, ResIdle},
      '{1'b0, 1'b0, 8'd10, 1'b0, ResIdle},
      '{1'b0, 1'b0, 8'd1, 1'b0, ResIdle},
      '{1'b0, 1'b1, 8'd1, 1'b0, ResIdle},
      '{1'b0, 1'b0, 8'd1, 1'b1, ResShortEcho}
    };
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      repeat (dir_rows[i].reps)
        send_beat(dir_rows[i].start, dir_rows[i].echo, dir_rows[i].typed, dir_rows[i].res);
    end

    for (int ph = 0; ph < NumPhases; ph++) begin
      drain_results();
      write_reg(CFG_MAX_DISTANCE, ph_dist[ph]);
      write_reg(CFG_ROUNDTRIP, ph_rt[ph]);
      write_reg(CFG_WARMUP, ph_warmup[ph]);
      write_reg(CFG_OVERHEAD, ph_overhead[ph]);
      cfg_we <= 1'b0;
      repeat (3) @(posedge clk);
      for (int i = 0; i < 4; i++) begin
        repeat ($urandom_range(0, 3)) send_beat(1'($urandom), 1'($urandom), 1'b0, '0);
        win = echo_window();
        rise = $urandom_range(0, (c_warmup < 30) ? int'(c_warmup) + 2 : 30);
        if (win < 40) wmax = win + 2;
        else if ($urandom_range(0, 7) == 0) wmax = (win < 400) ? win + 2 : 400;
        else wmax = 40;
        run_ping(rise, $urandom_range(1, wmax));
      end
    end

    drain_results();
    repeat (10) @(posedge clk);
    $display("Run covered %0d input beats under %0d register settings.", n_beats,
             NumPhases + 1);
    $display("%0d pings finished, %0d of them by a deadline.", n_done, n_timeouts);
    if (errors == 0) begin
      $display("[ultrasonic_echo_ranging] OK");
    end else begin
      $display("[ultrasonic_echo_ranging] ERROR");
    end
    $finish;
  end

endmodule
